FILE: sv/sorted_insert_deque_assert.svh
// ----------------------------------------------------------------------------
// sorted_insert_deque_assert.svh
// Assertion macros for the sorted insert deque checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_DEQUE_ASSERT_SVH
`define SORTED_INSERT_DEQUE_ASSERT_SVH

// Clocked assertion on clk, disabled while rst_n is low.
`define SID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication built on the clocked form.
`define SID_ASSERT_IMP(lbl, ante, cons, msg) \
  `SID_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: sv/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg
// Types and codes shared by the sorted insert deque modules.
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_POP_BACK   = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] entry_key;
    logic [63:0]        payload_in;
    logic [3:0]         length_in;
  } req_t;

  typedef struct packed {
    logic [63:0] payload_out;
    logic [3:0]  length_out;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic apply;
  } cmd_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EVAL,
    FSM_APPLY
  } fsm_t;

endpackage

FILE: sv/sid_ctrl.sv
// ----------------------------------------------------------------------------
// sid_ctrl
// Request sequencer: load, compare, apply, one request at a time.
// ----------------------------------------------------------------------------
module sid_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output sid_pkg::cmd_t cmd
);
  import sid_pkg::*;

  fsm_t state_r;
  fsm_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (start) state_nxt = FSM_EVAL;
      end
      FSM_EVAL:  state_nxt = FSM_APPLY;
      FSM_APPLY: state_nxt = FSM_IDLE;
      default:   state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    cmd.load  = 1'b0;
    cmd.eval  = 1'b0;
    cmd.apply = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      FSM_EVAL:  cmd.eval  = 1'b1;
      FSM_APPLY: cmd.apply = 1'b1;
      default:   busy      = 1'b1;
    endcase
  end

endmodule

FILE: sv/sid_dpath.sv
// ----------------------------------------------------------------------------
// sid_dpath
// Cell row of stored entries with per-cell key compare and shift steering.
// ----------------------------------------------------------------------------
module sid_dpath #(
  parameter int CAPACITY  = 16,
  parameter int MAX_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sid_pkg::cmd_t cmd,
  input  sid_pkg::req_t in_req,
  output logic          out_valid,
  output sid_pkg::rsp_t out_rsp
);
  import sid_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IW    = $clog2(CAPACITY);
  localparam int LOGN  = $clog2(CAPACITY);
  localparam int PAY_W = 8 * MAX_BYTES;
  localparam logic [3:0]    MAXB = 4'(MAX_BYTES);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  req_t                 req_r;
  logic [PAY_W-1:0]     req_pay_r;
  logic [3:0]           req_len_r;
  logic [3:0]           len_sat;
  logic [PAY_W-1:0]     pay_mask;

  logic signed [31:0]   key_r [CAPACITY];
  logic [PAY_W-1:0]     pay_r [CAPACITY];
  logic [3:0]           len_r [CAPACITY];
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;

  logic [CAPACITY-1:0]  hit;
  logic [CAPACITY-1:0]  pre;
  logic [CAPACITY-1:0]  sel_new_nxt;
  logic [CAPACITY-1:0]  sel_shift_nxt;
  logic [CAPACITY-1:0]  sel_new_r;
  logic [CAPACITY-1:0]  sel_shift_r;
  logic [PAY_W-1:0]     back_pay_r;
  logic [3:0]           back_len_r;
  logic [IW-1:0]        back_idx;

  logic                 is_put;
  logic                 full;
  logic                 empty;
  logic                 do_put;
  logic                 do_popf;
  rsp_t                 rsp_nxt;
  rsp_t                 rsp_r;
  logic                 valid_r;

  // Saturate the length and drop bytes beyond it before storing.
  always_comb begin
    len_sat = (in_req.length_in > MAXB) ? MAXB : in_req.length_in;
    for (int b = 0; b < MAX_BYTES; b++) begin
      pay_mask[8*b +: 8] = (4'(b) < len_sat) ? 8'hFF : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_req;
      req_len_r <= len_sat;
      req_pay_r <= in_req.payload_in[PAY_W-1:0] & pay_mask;
    end
  end

  // Per-cell compare, then a log-step prefix OR locates the first hit.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = (CW'(i) < count_r) &&
               ((req_r.operation == OP_INSERT) ?
                ($signed(req_r.entry_key) >= key_r[i]) :
                (req_r.operation == OP_PUSH_FRONT));
    end
    pre = hit;
    for (int s = 0; s < LOGN; s++) begin
      pre = pre | (pre << (1 << s));
    end
    sel_new_nxt   = '0;
    sel_shift_nxt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pre[CAPACITY-1]) begin
        sel_new_nxt[i] = (i == 0) ? pre[0] : (pre[i] && !pre[i-1]);
      end else begin
        sel_new_nxt[i] = (CW'(i) == count_r);
      end
    end
    for (int i = 1; i < CAPACITY; i++) begin
      sel_shift_nxt[i] = pre[i-1] && (CW'(i) <= count_r);
    end
    back_idx = IW'(count_r - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      sel_new_r   <= sel_new_nxt;
      sel_shift_r <= sel_shift_nxt;
      back_pay_r  <= pay_r[back_idx];
      back_len_r  <= len_r[back_idx];
    end
  end

  assign is_put  = (req_r.operation == OP_INSERT) || (req_r.operation == OP_PUSH_FRONT) ||
                   (req_r.operation == OP_PUSH_BACK);
  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_put  = cmd.apply && is_put && !full;
  assign do_popf = cmd.apply && (req_r.operation == OP_POP_FRONT) && !empty;

  always_comb begin
    count_nxt           = count_r;
    rsp_nxt.payload_out = '0;
    rsp_nxt.length_out  = '0;
    rsp_nxt.status      = ST_DONE;
    case (req_r.operation)
      OP_INSERT, OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) rsp_nxt.status = ST_FULL;
        else      count_nxt      = count_r + CW'(1);
      end
      OP_POP_FRONT: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          rsp_nxt.payload_out = 64'(pay_r[0]);
          rsp_nxt.length_out  = len_r[0];
          count_nxt           = count_r - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          rsp_nxt.payload_out = 64'(back_pay_r);
          rsp_nxt.length_out  = back_len_r;
          count_nxt           = count_r - CW'(1);
        end
      end
      OP_CLEAR: count_nxt = '0;
      default:  count_nxt = count_r;
    endcase
    rsp_nxt.occupancy = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.apply;
      if (cmd.apply) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) rsp_r <= rsp_nxt;
  end

  // Cell row: take the new entry, shift back from the neighbor in front,
  // or advance from the neighbor behind on a front pop.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_put && sel_new_r[g]) begin
        key_r[g] <= $signed(req_r.entry_key);
        pay_r[g] <= req_pay_r;
        len_r[g] <= req_len_r;
      end else if (do_put && sel_shift_r[g]) begin
        if (g > 0) begin
          key_r[g] <= key_r[(g > 0) ? g - 1 : 0];
          pay_r[g] <= pay_r[(g > 0) ? g - 1 : 0];
          len_r[g] <= len_r[(g > 0) ? g - 1 : 0];
        end
      end else if (do_popf) begin
        if (g < CAPACITY - 1) begin
          key_r[g] <= key_r[(g < CAPACITY - 1) ? g + 1 : g];
          pay_r[g] <= pay_r[(g < CAPACITY - 1) ? g + 1 : g];
          len_r[g] <= len_r[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end
  end

  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule

FILE: sv/sorted_insert_deque.sv
// An accepted request is loaded, compared across the cell row, then applied to the row;
// the result is registered and strobes on out_valid. busy stays high through the compare
// and update steps, so a new request is taken only after the last one is applied.
// Reset clears the entry count, the sequencer and the result strobe; cell contents hold.
// Results are shown for one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
// sorted_insert_deque
// Bounded ordered store with sorted insert, push and pop at both ends, clear.
// ----------------------------------------------------------------------------
module sorted_insert_deque #(
  parameter int CAPACITY  = 16,
  parameter int MAX_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sid_pkg::req_t in_req,
  output logic          out_valid,
  output sid_pkg::rsp_t out_rsp
);
  import sid_pkg::*;

  cmd_t cmd;

  sid_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  sid_dpath #(
    .CAPACITY  (CAPACITY),
    .MAX_BYTES (MAX_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

FILE: sv/sid_checker.sv
// ----------------------------------------------------------------------------
// sid_checker
// Port-level checks for the sorted insert deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_insert_deque_assert.svh"

module sid_checker #(
  parameter int CAPACITY  = 16,
  parameter int MAX_BYTES = 8
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input sid_pkg::req_t in_req,
  input logic          out_valid,
  input sid_pkg::rsp_t out_rsp
);
  import sid_pkg::*;

  localparam logic [4:0] FULL_OCC = 5'(CAPACITY);
  localparam logic [3:0] MAXB     = 4'(MAX_BYTES);

  `SID_ASSERT_IMP(a_req_gets_rsp, start && !busy, ##3 out_valid, "accepted request without result")
  `SID_ASSERT_IMP(a_clear_empties, start && !busy && in_req.operation == OP_CLEAR, ##3 (out_rsp.occupancy == 5'd0), "clear left entries")
  `SID_ASSERT_IMP(a_full_occ, out_valid && out_rsp.status == ST_FULL, out_rsp.occupancy == FULL_OCC, "full status with room left")
  `SID_ASSERT_IMP(a_empty_zero, out_valid && out_rsp.status == ST_EMPTY, out_rsp.occupancy == 5'd0 && out_rsp.payload_out == 64'd0 && out_rsp.length_out == 4'd0, "empty status with data")
  `SID_ASSERT_IMP(a_len_bound, out_valid, out_rsp.length_out <= MAXB, "length above byte limit")

endmodule

bind sorted_insert_deque sid_checker #(
  .CAPACITY  (CAPACITY),
  .MAX_BYTES (MAX_BYTES)
) u_sid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

FILE: bench/sorted_insert_deque_tb.sv
// ----------------------------------------------------------------------------
// sorted_insert_deque_tb
// Self-checking bench for the sorted insert deque. A queue of requests feeds
// a clocked driver that predicts each accepted request against its own copy
// of the store. A clocked monitor compares every strobed result with the
// oldest prediction. The run mixes directed corner cases with random fill,
// drain and mixed bursts under several sender idle rates.
// ----------------------------------------------------------------------------
module sorted_insert_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sid_pkg::*;

  localparam int CAPACITY  = 16;
  localparam int MAX_BYTES = 8;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS   = 200;

  // Operation codes with no defined action.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  start     = 1'b0;
  req_t  in_req    = '0;
  logic  busy;
  logic  out_valid;
  rsp_t  out_rsp;

  req_t  req_q[$];
  rsp_t  due_rsp[$];
  int    idle_pct = 0;
  int    errors   = 0;

  // Shadow copy of the store, front at index 0.
  logic signed [31:0] shadow_key [CAPACITY];
  logic [63:0]        shadow_pay [CAPACITY];
  logic [3:0]         shadow_len [CAPACITY];
  int                 shadow_count = 0;

  sorted_insert_deque #(
    .CAPACITY (CAPACITY),
    .MAX_BYTES(MAX_BYTES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_t apply_deque_op(req_t r);
    rsp_t        o;
    logic [3:0]  ln;
    logic [63:0] pay;
    int          pos;
    o = '0;
    o.status = ST_DONE;
    ln = (r.length_in > MAX_BYTES) ? 4'(MAX_BYTES) : r.length_in;
    // Drop bytes beyond the entry length.
    pay = (ln >= 8) ? r.payload_in : (r.payload_in & ((64'd1 << (8 * ln)) - 64'd1));
    case (r.operation)
      OP_INSERT, OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          if (r.operation == OP_PUSH_FRONT) begin
            pos = 0;
          end else if (r.operation == OP_PUSH_BACK) begin
            pos = shadow_count;
          end else begin
            pos = 0;
            while (pos < shadow_count && r.entry_key < shadow_key[pos]) pos++;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_pay[i] = shadow_pay[i-1];
            shadow_len[i] = shadow_len[i-1];
          end
          shadow_key[pos] = r.entry_key;
          shadow_pay[pos] = pay;
          shadow_len[pos] = ln;
          shadow_count++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.payload_out = shadow_pay[0];
          o.length_out  = shadow_len[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_key[i-1] = shadow_key[i];
            shadow_pay[i-1] = shadow_pay[i];
            shadow_len[i-1] = shadow_len[i];
          end
          shadow_count--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          shadow_count--;
          o.payload_out = shadow_pay[shadow_count];
          o.length_out  = shadow_len[shadow_count];
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
      end
      default: ;
    endcase
    o.occupancy = 5'(shadow_count);
    return o;
  endfunction

  function automatic req_t make_req(logic [2:0] op, logic signed [31:0] key,
                                    logic [63:0] pay, logic [3:0] len);
    req_t r;
    r.operation  = op;
    r.entry_key  = key;
    r.payload_in = pay;
    r.length_in  = len;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_key();
    int pick;
    pick = $urandom_range(9, 0);
    // Favor a narrow range so equal keys show up often.
    if (pick < 6) return 32'($signed($urandom_range(8, 0)) - 4);
    if (pick == 6) return KEY_MAX;
    if (pick == 7) return KEY_MIN;
    return $signed($urandom);
  endfunction

  function automatic req_t rand_req(logic [2:0] op);
    logic [3:0] len;
    len = ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 9))
                                      : 4'($urandom_range(8, 0));
    return make_req(op, rand_key(), {$urandom, $urandom}, len);
  endfunction

  function automatic logic [2:0] rand_store_op();
    int pick;
    pick = $urandom_range(5, 0);
    if (pick < 3) return OP_INSERT;
    if (pick == 3) return OP_PUSH_FRONT;
    return OP_PUSH_BACK;
  endfunction

  task automatic queue_random_phase(int n);
    int kind;
    int burst;
    int done_n;
    done_n = 0;
    while (done_n < n) begin
      kind  = $urandom_range(9, 0);
      burst = $urandom_range(20, 6);
      for (int i = 0; i < burst; i++) begin
        if (kind < 4)
          req_q.push_back(rand_req(rand_store_op()));
        else if (kind < 7)
          req_q.push_back(rand_req($urandom_range(1, 0) ? OP_POP_FRONT : OP_POP_BACK));
        else if (kind < 9)
          req_q.push_back(rand_req(3'($urandom_range(7, 0))));
        else if (i == 0)
          req_q.push_back(rand_req(OP_CLEAR));
        else
          req_q.push_back(rand_req($urandom_range(1, 0) ? OP_SPARE_6 : OP_SPARE_7));
      end
      done_n += burst;
    end
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  // Driver: hold a request while busy, otherwise advance or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        due_rsp.push_back(apply_deque_op(in_req));
      if (start && busy) begin
        start <= 1'b1;
      end else if (req_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        start  <= 1'b1;
        in_req <= req_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_rsp.size() == 0) begin
        $display("[%0t] result with no request outstanding", $realtime);
        errors++;
      end else begin
        rsp_t want;
        want = due_rsp.pop_front();
        if (out_rsp.payload_out !== want.payload_out)
          report_mismatch("payload_out", out_rsp.payload_out, want.payload_out);
        if (out_rsp.length_out !== want.length_out)
          report_mismatch("length_out", 64'(out_rsp.length_out), 64'(want.length_out));
        if (out_rsp.status !== want.status)
          report_mismatch("status", 64'(out_rsp.status), 64'(want.status));
        if (out_rsp.occupancy !== want.occupancy)
          report_mismatch("occupancy", 64'(out_rsp.occupancy), 64'(want.occupancy));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int phase_idle[4];
    phase_idle = '{0, 73, 29, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Pops and spare codes on an empty store.
    req_q.push_back(make_req(OP_POP_FRONT, 0, '1, 4'd8));
    req_q.push_back(make_req(OP_POP_BACK, 0, '1, 4'd8));
    req_q.push_back(make_req(OP_SPARE_6, KEY_MAX, '1, 4'd15));
    req_q.push_back(make_req(OP_SPARE_7, KEY_MIN, '1, 4'd0));
    // Fill to capacity: key extremes, equal keys, saturated and zero lengths.
    req_q.push_back(make_req(OP_INSERT, KEY_MAX, '1, 4'd15));
    req_q.push_back(make_req(OP_INSERT, KEY_MIN, '1, 4'd0));
    req_q.push_back(make_req(OP_INSERT, KEY_MAX, 64'h0123_4567_89ab_cdef, 4'd8));
    req_q.push_back(make_req(OP_INSERT, 0, '1, 4'd3));
    req_q.push_back(make_req(OP_INSERT, 0, 64'hfedc_ba98_7654_3210, 4'd1));
    req_q.push_back(make_req(OP_PUSH_FRONT, -1, '1, 4'd8));
    req_q.push_back(make_req(OP_PUSH_BACK, KEY_MAX, '1, 4'd4));
    for (int i = 0; i < 9; i++)
      req_q.push_back(rand_req(OP_INSERT));
    req_q.push_back(make_req(OP_INSERT, 0, '1, 4'd8));
    req_q.push_back(make_req(OP_PUSH_FRONT, 0, '1, 4'd8));
    req_q.push_back(make_req(OP_PUSH_BACK, 0, '1, 4'd8));
    req_q.push_back(make_req(OP_POP_FRONT, 0, 64'd0, 4'd0));
    req_q.push_back(make_req(OP_POP_BACK, 0, 64'd0, 4'd0));
    req_q.push_back(make_req(OP_CLEAR, 0, 64'd0, 4'd0));

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      queue_random_phase(PHASE_ITEMS);
      while (req_q.size() != 0) @(posedge clk);
    end

    @(posedge clk);
    while (start || due_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && due_rsp.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/sid_pkg.sv
sv/sid_ctrl.sv
sv/sid_dpath.sv
sv/sorted_insert_deque.sv
sv/sid_checker.sv
bench/sorted_insert_deque_tb.sv
